@@ design/assert_macros.svh @@
// Assertion macros used by xorshift128_bounded_random.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define XBR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define XBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define XBR_ASSERT(lbl, clk, rst_n, prop, msg)
`define XBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/xbr_pkg.sv @@
// Types and constants for the bounded xorshift128 random block.
// No dependencies.
package xbr_pkg;

    localparam int WORD_W  = 32;
    localparam int VALUE_W = 53;
    localparam int NUM_WORDS = 4;

    localparam int SHIFT_A = 11;
    localparam int SHIFT_B = 8;
    localparam int SHIFT_C = 19;

    localparam logic [WORD_W-1:0] SEED0_RST = 32'd123456789;
    localparam logic [WORD_W-1:0] SEED1_RST = 32'd362436069;
    localparam logic [WORD_W-1:0] SEED2_RST = 32'd521288629;
    localparam logic [WORD_W-1:0] SEED3_RST = 32'd88675123;

    typedef enum logic [1:0] {
        CMD_MOD    = 2'd0,
        CMD_UNIT24 = 2'd1,
        CMD_UNIT53 = 2'd2,
        CMD_RESEED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]        command;
        logic signed [31:0] limit;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               error;
    } t_out;

endpackage

@@ design/xorshift128_bounded_random.sv @@
// Bounded random-number block on an xorshift128 generator (shifts 11, 8, 19).
// Depends on xbr_pkg and assert_macros.svh.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries a command and
//   a signed limit. Each accepted transaction yields exactly one result on
//   the output channel (o_out_valid / i_out_ready / o_out_data).
//   One transaction is processed at a time; o_in_ready is high only while
//   the sequencer is idle.
//   States from acceptance to the edge that raises o_out_valid:
//     modulo draw: ST_DRAW, then the radix-2 restoring divider in ST_DIV,
//       then ST_FINISH; bad limit and reseed: ST_FINISH only
//     24-bit fraction: ST_DRAW, ST_FINISH; 53-bit: ST_DRAW twice, ST_FINISH
//   (one generator step per cycle). o_in_ready returns on that same edge.
//   The result sits in an output register; the next transaction is taken
//   while it waits. If the receiver stalls, a second finished result holds
//   in the finish state until the output register frees.
//   Seed registers are written through i_cfg_we / i_cfg_index / i_cfg_data
//   and take effect at the next reseed.
//   Synchronous active-low reset loads the default seeds into both the seed
//   registers and the generator state, and empties the output.
`include "assert_macros.svh"

module xorshift128_bounded_random
    import xbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [4:0] DIV_LAST = 5'(WORD_W - 1);

    t_state              r_state, n_state;
    logic [WORD_W-1:0]   r_gen  [NUM_WORDS];
    logic [WORD_W-1:0]   n_gen  [NUM_WORDS];
    logic [WORD_W-1:0]   r_seed [NUM_WORDS];
    logic [WORD_W-1:0]   n_seed [NUM_WORDS];
    t_cmd                r_cmd, n_cmd;
    logic [WORD_W-2:0]   r_lim, n_lim;
    logic [WORD_W-1:0]   r_first, n_first;
    logic                r_second, n_second;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic [WORD_W-1:0]   r_dvd, n_dvd;
    logic [4:0]          r_cnt, n_cnt;
    t_out                r_res, n_res;
    t_out                r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [WORD_W-1:0]   w_draw;
    logic [WORD_W-1:0]   w_t;
    logic [WORD_W-1:0]   w_trial;
    logic                w_accept;
    logic                w_lim_bad;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_lim_bad   = i_in_data.limit[31] || (i_in_data.limit == '0);

    always_comb begin
        w_t    = r_gen[3];
        w_t    = w_t ^ (w_t << SHIFT_A);
        w_t    = w_t ^ (w_t >> SHIFT_B);
        w_draw = w_t ^ r_gen[0] ^ (r_gen[0] >> SHIFT_C);
    end

    assign w_trial = {r_rem[WORD_W-2:0], r_dvd[WORD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_gen[0]    <= SEED0_RST;
            r_gen[1]    <= SEED1_RST;
            r_gen[2]    <= SEED2_RST;
            r_gen[3]    <= SEED3_RST;
            r_seed[0]   <= SEED0_RST;
            r_seed[1]   <= SEED1_RST;
            r_seed[2]   <= SEED2_RST;
            r_seed[3]   <= SEED3_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_gen       <= n_gen;
            r_seed      <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_lim    <= n_lim;
        r_first  <= n_first;
        r_second <= n_second;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_seed      = r_seed;
        n_cmd       = r_cmd;
        n_lim       = r_lim;
        n_first     = r_first;
        n_second    = r_second;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_cfg_we) begin
            n_seed[i_cfg_index] = i_cfg_data;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd    = t_cmd'(i_in_data.command);
                    n_lim    = i_in_data.limit[WORD_W-2:0];
                    n_second = 1'b0;
                    n_res    = '0;
                    case (t_cmd'(i_in_data.command))
                        CMD_MOD: begin
                            if (w_lim_bad) begin
                                n_res.error = 1'b1;
                                n_state     = ST_FINISH;
                            end else begin
                                n_state = ST_DRAW;
                            end
                        end
                        CMD_UNIT24, CMD_UNIT53: begin
                            n_state = ST_DRAW;
                        end
                        default: begin
                            n_gen   = r_seed;
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                n_gen[0] = w_draw;
                n_gen[1] = r_gen[0];
                n_gen[2] = r_gen[1];
                n_gen[3] = r_gen[2];
                case (r_cmd)
                    CMD_MOD: begin
                        n_dvd   = w_draw;
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end
                    CMD_UNIT24: begin
                        n_res.value = VALUE_W'(w_draw >> 8);
                        n_state     = ST_FINISH;
                    end
                    CMD_UNIT53: begin
                        if (!r_second) begin
                            n_first  = w_draw;
                            n_second = 1'b1;
                        end else begin
                            n_res.value = {r_first[WORD_W-1:5], w_draw[WORD_W-1:6]};
                            n_state     = ST_FINISH;
                        end
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_DIV: begin
                if (w_trial >= {1'b0, r_lim}) begin
                    n_rem = w_trial - {1'b0, r_lim};
                end else begin
                    n_rem = w_trial;
                end
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_res.value = VALUE_W'(n_rem);
                    n_state     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `XBR_ASSERT(a_div_nonzero, i_clk, i_rst_n, (r_state != ST_DIV) || (r_lim != '0), "divider running with zero limit")
    `XBR_ASSERT(a_err_zero, i_clk, i_rst_n, !(r_out_valid && r_out.error) || (r_out.value == '0), "error result with nonzero value")
    `XBR_ASSERT_NEXT(a_reseed, i_clk, i_rst_n, w_accept && (i_in_data.command == CMD_RESEED), (r_gen[0] == $past(r_seed[0])) && (r_gen[3] == $past(r_seed[3])), "reseed did not load seeds")

endmodule
